// ----- rtl/irbt3d_pkg.sv -----
// Shared types, constants and per-dimension helpers for the 3D restriction core.
// No dependencies; imported by image_restrict_by_two_3d_core.
`timescale 1ns / 1ps

package irbt3d_pkg;

  localparam int MAX_SIZE_X = 1024;
  localparam int MAX_SIZE_Y = 1024;
  localparam int DIMENSIONS = 3;

  localparam int SX_W     = $clog2(MAX_SIZE_X) + 1;  // size register widths
  localparam int SY_W     = $clog2(MAX_SIZE_Y) + 1;
  localparam int SZ_W     = 16;
  localparam int ROW_AW   = $clog2(MAX_SIZE_X);      // x position / row store index
  localparam int YW       = $clog2(MAX_SIZE_Y);      // y position
  localparam int PLANE_AW = ROW_AW + YW;             // plane store index

  localparam int SAMPLE_W = 16;
  localparam int XSUM_W   = 18;
  localparam int YSUM_W   = 20;
  localparam int ZSUM_W   = 22;
  localparam int VALUE_W  = 22;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Register map, one word per register.
  typedef enum logic [2:0] {
    REG_SIZE_X     = 3'd0,
    REG_SIZE_Y     = 3'd1,
    REG_SIZE_Z     = 3'd2,
    REG_RESTRICT_X = 3'd3,
    REG_RESTRICT_Y = 3'd4,
    REG_RESTRICT_Z = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIM_PASS,   // unrestricted or extent 1: weight 1
    DIM_PAIR,   // extent 2: [1 1]
    DIM_FULL    // [1 2 1]
  } dim_mode_t;

  typedef struct packed {
    dim_mode_t   mode;
    logic [15:0] m;       // (n-1)/2
    logic [15:0] olen;    // output extent
    logic [1:0]  dshift;  // log2 of weight denominator
  } dim_cfg_t;

  typedef struct packed {
    logic        done;    // an output completes along this dimension
    logic        wr;      // partial sum is updated
    logic        wr_add;  // update is acc + 2v, else v
    logic [15:0] j;       // output index when done
  } dim_ctrl_t;

  function automatic dim_cfg_t dim_setup(input logic [15:0] n, input logic r);
    dim_cfg_t c;
    c.m = (n - 16'd1) >> 1;
    if (!r || n < 16'd2) begin
      c.mode   = DIM_PASS;
      c.olen   = n;
      c.dshift = 2'd0;
    end else if (n == 16'd2) begin
      c.mode   = DIM_PAIR;
      c.olen   = 16'd1;
      c.dshift = 2'd1;
    end else begin
      c.mode   = DIM_FULL;
      c.olen   = c.m;
      c.dshift = 2'd2;
    end
    return c;
  endfunction

  // Control for one dimension depends only on the position, not on data.
  function automatic dim_ctrl_t dim_ctrl(input dim_cfg_t c, input logic [15:0] i);
    dim_ctrl_t   d;
    logic [15:0] half;
    half = {1'b0, i[15:1]};
    d    = '0;
    case (c.mode)
      DIM_PASS: begin
        d.done = 1'b1;
        d.j    = i;
      end
      DIM_PAIR: begin
        if (i == 16'd0) begin
          d.wr = 1'b1;
        end else begin
          d.done = 1'b1;
        end
      end
      DIM_FULL: begin
        if (i[0]) begin
          d.wr     = (half < c.m);
          d.wr_add = 1'b1;
        end else begin
          d.done = (half != 16'd0) && ((half - 16'd1) < c.m);
          d.j    = half - 16'd1;
          d.wr   = (half < c.m);
        end
      end
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/image_restrict_by_two_3d_core.sv -----
// Streaming 3D full-weighting restriction core: x, row and plane partial-sum pipeline.
// Depends on irbt3d_pkg (types, constants, per-dimension control functions).
`timescale 1ns / 1ps

// Samples of a volume arrive in raster order (x fastest, then y, then z) on the
// slave stream, one transfer per cycle when nothing downstream holds back. Each
// restricted dimension of extent n shrinks to (n-1)/2 (at least 1) with separable
// weights [1 2 1]/4, or [1 1]/2 for extent 2; an extent of 1 or a cleared restrict
// bit passes that dimension through. Every finished output is sent exactly, scaled
// by 64, with tlast on the final output of the volume. Throughput is one sample per
// clock while tready stays high; a result reaches the master side through the input
// stage, the registered read of the row store, the registered read of the plane store
// and the write into the output queue. An 8-entry output queue with credit counting
// lets samples keep flowing while a result waits; once eight transfers are queued or
// in flight tready drops until the sink takes one or an in-flight sample leaves the
// pipeline without a result. Any write to a mapped register restarts the volume at
// position zero; partial sums are not cleared and need no clearing pass, as each
// entry is written before it is read within a volume streamed in order.
module image_restrict_by_two_3d_core (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [21:0] value, [23:22] zero
  output logic        m_tlast,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import irbt3d_pkg::*;

  // ---------------------------------------------------------------- registers
  logic [SX_W-1:0] size_x;
  logic [SY_W-1:0] size_y;
  logic [SZ_W-1:0] size_z;
  logic            restrict_x, restrict_y, restrict_z;

  logic     cfg_wr;
  cfg_reg_t cfg_sel;
  logic     cfg_hit;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_sel)
      REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z,
      REG_RESTRICT_X, REG_RESTRICT_Y, REG_RESTRICT_Z: cfg_hit = 1'b1;
      default:                                        cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= SX_W'(1);
      size_y     <= SY_W'(1);
      size_z     <= SZ_W'(1);
      restrict_x <= 1'b1;
      restrict_y <= 1'b1;
      restrict_z <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_SIZE_X:     size_x     <= pwdata[SX_W-1:0];
        REG_SIZE_Y:     size_y     <= pwdata[SY_W-1:0];
        REG_SIZE_Z:     size_z     <= pwdata[SZ_W-1:0];
        REG_RESTRICT_X: restrict_x <= pwdata[0];
        REG_RESTRICT_Y: restrict_y <= pwdata[0];
        REG_RESTRICT_Z: restrict_z <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_SIZE_X:     prdata = 32'(size_x);
      REG_SIZE_Y:     prdata = 32'(size_y);
      REG_SIZE_Z:     prdata = 32'(size_z);
      REG_RESTRICT_X: prdata = 32'(restrict_x);
      REG_RESTRICT_Y: prdata = 32'(restrict_y);
      REG_RESTRICT_Z: prdata = 32'(restrict_z);
      default:        prdata = '0;
    endcase
  end

  // ------------------------------------------------------- derived geometry
  // Zero acts as one; oversize x and y extents saturate at the store limits.
  logic [SX_W-1:0] sx;
  logic [SY_W-1:0] sy;
  logic [SZ_W-1:0] sz;
  dim_cfg_t        cfg_x, cfg_y, cfg_z;
  logic [2:0]      out_shift;

  always_comb begin
    sx = (size_x == '0) ? SX_W'(1)
       : (size_x > SX_W'(MAX_SIZE_X)) ? SX_W'(MAX_SIZE_X) : size_x;
    sy = (DIMENSIONS < 2 || size_y == '0) ? SY_W'(1)
       : (size_y > SY_W'(MAX_SIZE_Y)) ? SY_W'(MAX_SIZE_Y) : size_y;
    sz = (DIMENSIONS < 3 || size_z == '0) ? SZ_W'(1) : size_z;
    cfg_x = dim_setup(16'(sx), restrict_x);
    cfg_y = dim_setup(16'(sy), restrict_y);
    cfg_z = dim_setup(16'(sz), restrict_z);
    out_shift = 3'd6 - 3'(cfg_x.dshift) - 3'(cfg_y.dshift) - 3'(cfg_z.dshift);
  end

  // ------------------------------------------------------ input position
  logic [ROW_AW-1:0] pos_x;
  logic [YW-1:0]     pos_y;
  logic [SZ_W-1:0]   pos_z;
  logic              accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (cfg_wr && cfg_hit) begin
      // restart the volume
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept) begin
      if (SX_W'(pos_x) == sx - SX_W'(1)) begin
        pos_x <= '0;
        if (SY_W'(pos_y) == sy - SY_W'(1)) begin
          pos_y <= '0;
          pos_z <= (pos_z == sz - SZ_W'(1)) ? '0 : pos_z + SZ_W'(1);
        end else begin
          pos_y <= pos_y + YW'(1);
        end
      end else begin
        pos_x <= pos_x + ROW_AW'(1);
      end
    end
  end

  // Per-dimension control from the position alone.
  dim_ctrl_t in_cx, in_cy, in_cz;
  logic      in_last;

  always_comb begin
    in_cx   = dim_ctrl(cfg_x, 16'(pos_x));
    in_cy   = dim_ctrl(cfg_y, 16'(pos_y));
    in_cz   = dim_ctrl(cfg_z, pos_z);
    in_last = (in_cx.j == cfg_x.olen - 16'd1) && (in_cy.j == cfg_y.olen - 16'd1) &&
              (in_cz.j == cfg_z.olen - 16'd1);
  end

  // --------------------------------------------------------- stage A: x sums
  logic                a_valid;
  logic [SAMPLE_W-1:0] a_sample;
  dim_ctrl_t           a_cx, a_cy, a_cz;
  logic                a_last;
  logic [XSUM_W-1:0]   x_partial;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else     a_valid <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_sample <= s_tdata;
      a_cx     <= in_cx;
      a_cy     <= in_cy;
      a_cz     <= in_cz;
      a_last   <= in_last;
    end
  end

  logic [XSUM_W-1:0]   vx, x_wd;
  logic [ROW_AW-1:0]   a_jx;
  logic [PLANE_AW-1:0] a_idx;

  always_comb begin
    vx    = (a_cx.wr_add || cfg_x.mode == DIM_PASS) ? XSUM_W'(a_sample)
          : x_partial + XSUM_W'(a_sample);
    if (cfg_x.mode != DIM_PASS) vx = x_partial + XSUM_W'(a_sample);
    x_wd  = a_cx.wr_add ? x_partial + {1'b0, a_sample, 1'b0} : XSUM_W'(a_sample);
    a_jx  = a_cx.j[ROW_AW-1:0];
    a_idx = PLANE_AW'(a_cy.j[YW-1:0]) * PLANE_AW'(cfg_x.olen[SX_W-1:0]) +
            PLANE_AW'(a_jx);
  end

  // x_partial only ever feeds the next item through stage A, so no hazard.
  always_ff @(posedge clk) begin
    if (rst)                     x_partial <= '0;
    else if (a_valid && a_cx.wr) x_partial <= x_wd;
  end

  // --------------------------------------------------------- stage B: y sums
  logic                b_valid, b_go;
  logic [XSUM_W-1:0]   b_vx;
  dim_ctrl_t           b_cy, b_cz;
  logic [ROW_AW-1:0]   b_jx;
  logic [PLANE_AW-1:0] b_idx;
  logic                b_last;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else     b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    b_go   <= a_cx.done;
    b_vx   <= vx;
    b_cy   <= a_cy;
    b_cz   <= a_cz;
    b_jx   <= a_jx;
    b_idx  <= a_idx;
    b_last <= a_last;
  end

  // Row store: written from stage B, read for stage A; the write of the item just
  // ahead is forwarded into the read data.
  logic [YSUM_W-1:0] row_mem [MAX_SIZE_X];
  logic [YSUM_W-1:0] row_rd, row_wd, vy;
  logic              row_we;

  always_comb begin
    row_we = b_valid && b_go && b_cy.wr;
    row_wd = b_cy.wr_add ? row_rd + {1'b0, b_vx, 1'b0} : YSUM_W'(b_vx);
    vy     = (cfg_y.mode == DIM_PASS) ? YSUM_W'(b_vx) : row_rd + YSUM_W'(b_vx);
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[b_jx] <= row_wd;
    row_rd <= (row_we && b_jx == a_jx) ? row_wd : row_mem[a_jx];
  end

  // --------------------------------------------------------- stage C: z sums
  logic                c_valid, c_go;
  logic [YSUM_W-1:0]   c_vy;
  dim_ctrl_t           c_cz;
  logic [PLANE_AW-1:0] c_idx;
  logic                c_last;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else     c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    c_go   <= b_go && b_cy.done;
    c_vy   <= vy;
    c_cz   <= b_cz;
    c_idx  <= b_idx;
    c_last <= b_last;
  end

  logic [ZSUM_W-1:0] plane_mem [2**PLANE_AW];
  logic [ZSUM_W-1:0] plane_rd, plane_wd, vz;
  logic              plane_we;
  logic [VALUE_W-1:0] res_value;
  logic              push;

  always_comb begin
    plane_we  = c_valid && c_go && c_cz.wr;
    plane_wd  = c_cz.wr_add ? plane_rd + {1'b0, c_vy, 1'b0} : ZSUM_W'(c_vy);
    vz        = (cfg_z.mode == DIM_PASS) ? ZSUM_W'(c_vy) : plane_rd + ZSUM_W'(c_vy);
    res_value = VALUE_W'(vz << out_shift);
    push      = c_valid && c_go && c_cz.done;
  end

  always_ff @(posedge clk) begin
    if (plane_we) plane_mem[c_idx] <= plane_wd;
    plane_rd <= (plane_we && c_idx == b_idx) ? plane_wd : plane_mem[b_idx];
  end

  // ----------------------------------------------------------- output queue
  logic [VALUE_W:0]  fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   fifo_count;
  logic [FIFO_AW+1:0] credits_used;
  logic               pop;

  assign m_tvalid = (fifo_count != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {2'b00, fifo_mem[rd_ptr][VALUE_W-1:0]};
  assign m_tlast  = fifo_mem[rd_ptr][VALUE_W];

  // Every item in flight holds a credit, whether or not it ends in a result.
  assign credits_used = (FIFO_AW+2)'(fifo_count) + (FIFO_AW+2)'(a_valid) +
                        (FIFO_AW+2)'(b_valid) + (FIFO_AW+2)'(c_valid);
  assign s_tready     = (credits_used < (FIFO_AW+2)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr] <= {c_last, res_value};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_AW'(1);
      if (push && !pop)      fifo_count <= fifo_count + (FIFO_AW+1)'(1);
      else if (pop && !push) fifo_count <= fifo_count - (FIFO_AW+1)'(1);
    end
  end

  // ------------------------------------------------------------- assertions
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count < (FIFO_AW+1)'(FIFO_DEPTH) || pop))
    else $error("output queue overflow");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (fifo_count == (FIFO_AW+1)'(FIFO_DEPTH)) |-> !s_tready)
    else $error("input taken with output queue full");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (SX_W'(pos_x) < sx) && (SY_W'(pos_y) < sy) && (pos_z < sz))
    else $error("input position outside volume");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> a_valid)
    else $error("accepted sample did not enter the pipeline");

endmodule
